[rtl/dual_pwm_feedback_angle_decoder_defines.svh]
// assertion macros for the dual pwm feedback angle decoder
// used by the top level; expects clk and arst_n in scope
`ifndef DUAL_PWM_FEEDBACK_ANGLE_DECODER_DEFINES_SVH
`define DUAL_PWM_FEEDBACK_ANGLE_DECODER_DEFINES_SVH

// same-cycle implication
`define DPFAD_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define DPFAD_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

[rtl/dpfad_pkg.sv]
// shared types and constants for the dual pwm feedback angle decoder
// no dependencies
package dpfad_pkg;

	localparam int CAP_W       = 11;
	localparam int TICKS_W     = 19;
	localparam int ANGLE_W     = 18;
	localparam int TICKS_MAX   = 524287;
	localparam int ANGLE_MAX   = 131071;

	localparam int TIMER_PERIOD_DEF = 1099;
	localparam int WRAP_LIMIT_DEF   = 255;
	localparam int QUEUE_DEPTH_DEF  = 2;

	// angle = ((pct*3600) - 10440) / 898, truncated toward zero
	localparam int PCT_SCALE = 100;
	localparam int ANG_MUL   = 3600;
	localparam int ANG_OFS   = 10440;
	localparam int ANG_DIV   = 898;
	localparam int ANG_DIV_W = 10;

	typedef enum logic [1:0] {
		ACT_WRAP  = 2'd0,
		ACT_EDGE1 = 2'd1,
		ACT_EDGE2 = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

endpackage

[rtl/dpfad_fifo.sv]
// small register queue between the front and back parts
// depends on nothing but its parameters
module dpfad_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !(pop && !empty)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/dpfad_div.sv]
// divide by a constant through a reciprocal multiply, quotient registered in the cycle after start
// depends on nothing but its parameters
module dpfad_div #(
	parameter int DW      = 26,
	parameter int DIVISOR = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	output logic          done,
	output logic [DW-1:0] quotient
);

	// exact for every dividend below 2**DW
	localparam int SH = DW + $clog2(DIVISOR);
	localparam int MW = DW + 1;
	localparam int PW = DW + MW;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

	logic [PW-1:0] prod_q;
	logic          done_q;

	assign done     = done_q;
	assign quotient = prod_q[SH +: DW];

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PW'(dividend) * PW'(RECIP_M);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

endmodule

[rtl/dpfad_front.sv]
// front part: takes beats, keeps per-channel pulse state, queues closed pulses
// depends on dpfad_pkg
module dpfad_front
	import dpfad_pkg::*;
#(
	parameter int TIMER_PERIOD = TIMER_PERIOD_DEF,
	parameter int WRAP_LIMIT   = WRAP_LIMIT_DEF,
	parameter int END_W        = 32,
	parameter int WRAPS_W      = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [1:0]               action,
	input  logic [CAP_W-1:0]         capture_value,
	output logic                     push,
	output logic [END_W+CAP_W:0]     entry
);

	logic               high_q  [2];
	logic [CAP_W-1:0]   start_q [2];
	logic [WRAPS_W-1:0] wraps_q [2];
	action_t            act;
	logic               ch;
	logic [END_W-1:0]   end_cnt;

	assign act     = action_t'(action);
	assign ch      = (act == ACT_EDGE2);
	assign end_cnt = END_W'(capture_value) + END_W'(TIMER_PERIOD) * END_W'(wraps_q[ch]);
	assign push    = accept && (act == ACT_EDGE1 || act == ACT_EDGE2) && high_q[ch];
	assign entry   = {ch, end_cnt, start_q[ch]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				high_q[i]  <= 1'b0;
				start_q[i] <= '0;
				wraps_q[i] <= '0;
			end
		end else if (accept) begin
			unique case (act)
				ACT_WRAP: begin
					for (int i = 0; i < 2; i++) begin
						if (wraps_q[i] < WRAPS_W'(WRAP_LIMIT)) begin
							wraps_q[i] <= wraps_q[i] + 1'b1;
						end
					end
				end
				ACT_EDGE1, ACT_EDGE2: begin
					if (!high_q[ch]) begin
						high_q[ch]  <= 1'b1;
						start_q[ch] <= capture_value;
						wraps_q[ch] <= '0;
					end else begin
						high_q[ch] <= 1'b0;
					end
				end
				ACT_NONE: begin
				end
			endcase
		end
	end

endmodule

[rtl/dpfad_back.sv]
// back part: width, percent and angle through two reciprocal dividers, output register
// depends on dpfad_pkg and dpfad_div
module dpfad_back
	import dpfad_pkg::*;
#(
	parameter int TIMER_PERIOD = TIMER_PERIOD_DEF,
	parameter int END_W        = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  logic [END_W+CAP_W:0] entry,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_channel,
	output logic [TICKS_W-1:0]   out_ticks,
	output logic [ANGLE_W-1:0]   out_angle
);

	localparam int PCT_W   = $clog2(PCT_SCALE * TICKS_MAX / TIMER_PERIOD + 1);
	localparam int DVA_W   = TICKS_W + 7;
	// largest magnitude whose quotient does not exceed the positive angle limit
	localparam int SAT_MAG = (ANGLE_MAX + 1) * ANG_DIV - 1;
	localparam int DVB_W   = $clog2(SAT_MAG + 1);
	localparam int PROD_W  = (PCT_W + 12 > DVB_W) ? PCT_W + 12 : DVB_W;
	localparam int CMP_W   = (END_W > TICKS_W) ? END_W : TICKS_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PCT, ST_PCT_W, ST_MUL, ST_ANG, ST_ANG_W, ST_OUT
	} state_t;

	state_t              state_q;
	logic                ch_q;
	logic [TICKS_W-1:0]  width_q;
	logic [PCT_W-1:0]    pct_q;
	logic [PROD_W-1:0]   prod_q;
	logic                neg_q;
	logic                pct_start_q;
	logic                ang_start_q;
	logic [DVA_W-1:0]    pct_dvd_q;
	logic [DVB_W-1:0]    ang_dvd_q;
	logic                pct_done;
	logic [DVA_W-1:0]    pct_quo;
	logic                ang_done;
	logic [DVB_W-1:0]    ang_quo;
	logic                e_ch;
	logic [END_W-1:0]    e_end;
	logic [CAP_W-1:0]    e_start;
	logic [CMP_W-1:0]    diff;
	logic [TICKS_W-1:0]  width_sat;
	logic                prod_neg;
	logic [PROD_W-1:0]   mag;
	logic [DVB_W-1:0]    mag_sat;
	logic [ANGLE_W-1:0]  angle;

	assign {e_ch, e_end, e_start} = entry;
	assign diff = CMP_W'(e_end) - CMP_W'(e_start);
	assign pop  = (state_q == ST_IDLE) && !empty;

	always_comb begin
		if (e_end < END_W'(e_start)) begin
			width_sat = '0;
		end else if (diff > CMP_W'(TICKS_MAX)) begin
			width_sat = TICKS_W'(TICKS_MAX);
		end else begin
			width_sat = diff[TICKS_W-1:0];
		end
	end

	assign prod_neg = (prod_q < PROD_W'(ANG_OFS));
	assign mag = prod_neg ? PROD_W'(ANG_OFS) - prod_q : prod_q - PROD_W'(ANG_OFS);
	assign mag_sat = (mag > PROD_W'(SAT_MAG)) ? DVB_W'(SAT_MAG) : mag[DVB_W-1:0];

	assign angle = neg_q ? ANGLE_W'(0) - ang_quo[ANGLE_W-1:0] : ang_quo[ANGLE_W-1:0];

	dpfad_div #(
		.DW     (DVA_W),
		.DIVISOR(TIMER_PERIOD)
	) u_pct_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pct_start_q),
		.dividend(pct_dvd_q),
		.done    (pct_done),
		.quotient(pct_quo)
	);

	dpfad_div #(
		.DW     (DVB_W),
		.DIVISOR(ANG_DIV)
	) u_ang_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ang_start_q),
		.dividend(ang_dvd_q),
		.done    (ang_done),
		.quotient(ang_quo)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ch_q    <= e_ch;
				width_q <= width_sat;
			end
			ST_PCT: begin
				pct_dvd_q <= DVA_W'(width_q) * DVA_W'(PCT_SCALE);
			end
			ST_PCT_W: begin
				pct_q <= pct_quo[PCT_W-1:0];
			end
			ST_MUL: begin
				prod_q <= PROD_W'(pct_q) * PROD_W'(ANG_MUL);
			end
			ST_ANG: begin
				neg_q     <= prod_neg;
				ang_dvd_q <= mag_sat;
			end
			ST_ANG_W: begin
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pct_start_q <= 1'b0;
			ang_start_q <= 1'b0;
			out_valid   <= 1'b0;
			out_channel <= 1'b0;
			out_ticks   <= '0;
			out_angle   <= '0;
		end else begin
			pct_start_q <= 1'b0;
			ang_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q <= ST_PCT;
					end
				end
				ST_PCT: begin
					pct_start_q <= 1'b1;
					state_q     <= ST_PCT_W;
				end
				ST_PCT_W: begin
					if (pct_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ANG;
				end
				ST_ANG: begin
					ang_start_q <= 1'b1;
					state_q     <= ST_ANG_W;
				end
				ST_ANG_W: begin
					if (ang_done) begin
						out_channel <= ch_q;
						out_ticks   <= width_q;
						out_angle   <= angle;
						out_valid   <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/dual_pwm_feedback_angle_decoder.sv]
// top level of the dual pwm feedback angle decoder
// depends on dpfad_pkg, dpfad_front, dpfad_fifo, dpfad_back and the defines header
//
// channel   bus      tdata                                  tuser
// input     s_axis   [10:0] capture_value                   [1:0] action
// output    m_axis   [18:0] pulse_ticks, [36:19] angle_deg  [0] channel
//
// wraps, first edges and unused codes are accepted while the queue has room
// with the back idle, a closing edge goes via the queue and ST_PCT to ST_ANG_W to m_axis
// the back pops a new closing edge only once m_axis takes a beat (two reciprocal divides)
// arst_n clears pulse state, the queue and the back sequencer
// a stalled m_axis holds its beat; the queue keeps s_axis moving until it is full
`include "dual_pwm_feedback_angle_decoder_defines.svh"

module dual_pwm_feedback_angle_decoder
	import dpfad_pkg::*;
#(
	parameter int TIMER_PERIOD = TIMER_PERIOD_DEF,
	parameter int WRAP_LIMIT   = WRAP_LIMIT_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // capture_value
	input  logic [1:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // pulse_ticks, angle_deg
	output logic        m_axis_tuser   // channel
);

	localparam int WRAPS_W = $clog2(WRAP_LIMIT + 1);
	localparam int PW      = $clog2(TIMER_PERIOD + 1) + WRAPS_W;
	localparam int END_W   = ((PW > CAP_W) ? PW : CAP_W) + 1;
	localparam int ENT_W   = END_W + CAP_W + 1;

	logic               accept;
	logic               fifo_push;
	logic [ENT_W-1:0]   fifo_wdata;
	logic               fifo_full;
	logic               fifo_pop;
	logic [ENT_W-1:0]   fifo_rdata;
	logic               fifo_empty;
	logic [TICKS_W-1:0] out_ticks;
	logic [ANGLE_W-1:0] out_angle;

	assign s_axis_tready = !fifo_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tdata  = {3'b000, out_angle, out_ticks};

	dpfad_front #(
		.TIMER_PERIOD(TIMER_PERIOD),
		.WRAP_LIMIT  (WRAP_LIMIT),
		.END_W       (END_W),
		.WRAPS_W     (WRAPS_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (s_axis_tuser),
		.capture_value(s_axis_tdata[CAP_W-1:0]),
		.push         (fifo_push),
		.entry        (fifo_wdata)
	);

	dpfad_fifo #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fifo_push),
		.wdata (fifo_wdata),
		.full  (fifo_full),
		.pop   (fifo_pop),
		.rdata (fifo_rdata),
		.empty (fifo_empty)
	);

	dpfad_back #(
		.TIMER_PERIOD(TIMER_PERIOD),
		.END_W       (END_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (fifo_empty),
		.entry      (fifo_rdata),
		.pop        (fifo_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_channel(m_axis_tuser),
		.out_ticks  (out_ticks),
		.out_angle  (out_angle)
	);

	`DPFAD_ASSERT_IMP(a_no_push_when_full, fifo_push, !fifo_full)
	`DPFAD_ASSERT_IMP(a_zero_width_angle, m_axis_tvalid && out_ticks == '0,
		out_angle == -ANGLE_W'(11))
	`DPFAD_ASSERT_IMP(a_negative_only_short, m_axis_tvalid && out_angle[ANGLE_W-1],
		(40'(out_ticks) * 40'(PCT_SCALE)) < 40'(3 * TIMER_PERIOD))
	`DPFAD_ASSERT_NXT(a_pop_starts_work, fifo_pop, !m_axis_tvalid)

endmodule
